FILE: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the RTL; they compile to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property checked on every rising clock edge outside reset
`define PAL_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");
// same, also checked while reset is asserted
`define PAL_ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define PAL_ASSERT(lbl, clk, rst_n, prop)
`define PAL_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

FILE: src/pal_pkg.sv
// ----------------------------------------------------------------------------
// pal_pkg
// Constants, codes and types of the positional array list.
// ----------------------------------------------------------------------------
`default_nettype none

package pal_pkg;

	localparam int DEPTH      = 64;
	localparam int DATA_WIDTH = 32;

	localparam int IDX_W   = $clog2(DEPTH);
	localparam int COUNT_W = $clog2(DEPTH + 1);
	localparam int FUNC_W  = 3;
	localparam int POS_W   = 7;
	localparam int EDATA_W = 32;
	localparam int STAT_W  = 2;
	localparam int CNT_O_W = 7;
	localparam int WIDE_W  = (POS_W > COUNT_W) ? POS_W : COUNT_W;

	localparam int GRP   = 8;
	localparam int NGRP  = (DEPTH + GRP - 1) / GRP;

	localparam int IN_W  = ((FUNC_W + POS_W + EDATA_W + 7) / 8) * 8;
	localparam int OUT_W = ((EDATA_W + STAT_W + CNT_O_W + 7) / 8) * 8;

	localparam logic [FUNC_W-1:0] F_INS_HEAD = 3'd0;
	localparam logic [FUNC_W-1:0] F_INS_TAIL = 3'd1;
	localparam logic [FUNC_W-1:0] F_INS_POS  = 3'd2;
	localparam logic [FUNC_W-1:0] F_REM_HEAD = 3'd3;
	localparam logic [FUNC_W-1:0] F_REM_TAIL = 3'd4;
	localparam logic [FUNC_W-1:0] F_REM_POS  = 3'd5;

	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;
	localparam logic [STAT_W-1:0] ST_RANGE = 2'd3;

	typedef struct packed {
		logic                  ins;
		logic                  rem;
		logic [IDX_W-1:0]      at;
		logic [DATA_WIDTH-1:0] data;
	} cmd_t;

endpackage

`default_nettype wire

FILE: src/positional_array_list.sv
// ----------------------------------------------------------------------------
// positional_array_list
// Bounded ordered list of handles kept in a row of shifting slot cells.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one operation per word: tdata = {entry_data, position,
//   func}, func in the low bits. m_axis returns one word per operation:
//   tdata = {count_after, status, removed_data}, removed_data in the low bits.
//   Each accepted operation is applied to the slot cells in the cycle it is taken,
//   so a new operation can enter every cycle while the output side keeps up.
//   The removed handle is picked in two steps: gated per cell and OR-ed in
//   groups of eight into a register, then the group results are OR-ed into
//   the output register.
//   If m_axis is stalled, one operation waits in the middle stage and one in
//   the output register; s_axis_tready then drops until the output drains.
//   Reset clears the count (list empty) and drops all valid flags; slot
//   contents are not cleared and are never read before being written.
// ----------------------------------------------------------------------------
`default_nettype none

module positional_array_list (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         s_axis_tvalid,
	output logic                        s_axis_tready,
	// func[2:0], position[9:3], entry_data[41:10], zero pad above
	input  wire  [pal_pkg::IN_W-1:0]    s_axis_tdata,
	output logic                        m_axis_tvalid,
	input  wire                         m_axis_tready,
	// removed_data[31:0], status[33:32], count_after[40:34], zero pad above
	output logic [pal_pkg::OUT_W-1:0]   m_axis_tdata
);
	import pal_pkg::*;
	`include "assert_macros.svh"

	localparam int PAD_W = OUT_W - EDATA_W - STAT_W - CNT_O_W;

	logic                  fire;
	cmd_t                  cmd;
	logic [STAT_W-1:0]     status;
	logic [COUNT_W-1:0]    count_after;
	logic [COUNT_W-1:0]    count;

	logic [DATA_WIDTH-1:0] slot [DEPTH];
	logic [DATA_WIDTH-1:0] take [NGRP*GRP];

	logic                  valid_s1;
	logic [STAT_W-1:0]     status_s1;
	logic [COUNT_W-1:0]    count_s1;
	logic [DATA_WIDTH-1:0] grp_s1 [NGRP];
	logic [DATA_WIDTH-1:0] grp_or [NGRP];
	logic [DATA_WIDTH-1:0] removed;
	logic                  advance;

	logic                  out_valid_q;
	logic [OUT_W-1:0]      out_data_q;

	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign fire          = s_axis_tvalid && s_axis_tready;

	pal_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (fire),
		.func       (s_axis_tdata[FUNC_W-1:0]),
		.position   (s_axis_tdata[FUNC_W +: POS_W]),
		.entry_data (s_axis_tdata[FUNC_W+POS_W +: EDATA_W]),
		.cmd        (cmd),
		.status     (status),
		.count_after(count_after),
		.count      (count)
	);

	for (genvar i = 0; i < NGRP*GRP; i++) begin : g_cell
		if (i < DEPTH) begin : g_live
			pal_cell u_cell (
				.clk     (clk),
				.cell_idx(IDX_W'(i)),
				.cmd     (cmd),
				.left    ((i == 0) ? slot[0] : slot[(i == 0) ? 0 : i-1]),
				.right   ((i == DEPTH-1) ? '0 : slot[(i == DEPTH-1) ? i : i+1]),
				.slot    (slot[i]),
				.take    (take[i])
			);
		end else begin : g_pad
			assign take[i] = '0;
		end
	end

	for (genvar g = 0; g < NGRP; g++) begin : g_grp
		always_comb begin
			grp_or[g] = '0;
			for (int j = 0; j < GRP; j++) begin
				grp_or[g] = grp_or[g] | take[g*GRP + j];
			end
		end
	end

	always_comb begin
		removed = '0;
		for (int g = 0; g < NGRP; g++) begin
			removed = removed | grp_s1[g];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (fire) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			status_s1 <= status;
			count_s1  <= count_after;
			for (int g = 0; g < NGRP; g++) begin
				grp_s1[g] <= grp_or[g];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q <= {PAD_W'(0), CNT_O_W'(count_s1), status_s1, EDATA_W'(removed)};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	`PAL_ASSERT_ALWAYS(a_count_bound, clk, count <= COUNT_W'(DEPTH))
	`PAL_ASSERT(a_count_hold, clk, arst_n, !fire |=> $stable(count))
	`PAL_ASSERT(a_removed_zero, clk, arst_n,
		(valid_s1 && (status_s1 != ST_OK)) |-> (removed == '0))
	`PAL_ASSERT(a_stall_blocks, clk, arst_n,
		(valid_s1 && out_valid_q && !m_axis_tready) |-> !s_axis_tready)

endmodule

`default_nettype wire

FILE: src/pal_cell.sv
// ----------------------------------------------------------------------------
// pal_cell
// One slot of the list; shifts up or down with its neighbors on command.
// ----------------------------------------------------------------------------
`default_nettype none

module pal_cell (
	input  wire                           clk,
	input  wire  [pal_pkg::IDX_W-1:0]      cell_idx,
	input  wire  pal_pkg::cmd_t           cmd,
	input  wire  [pal_pkg::DATA_WIDTH-1:0] left,
	input  wire  [pal_pkg::DATA_WIDTH-1:0] right,
	output logic [pal_pkg::DATA_WIDTH-1:0] slot,
	output logic [pal_pkg::DATA_WIDTH-1:0] take
);
	import pal_pkg::*;

	logic [DATA_WIDTH-1:0] slot_q;

	always_ff @(posedge clk) begin
		if (cmd.ins) begin
			if (cell_idx == cmd.at) begin
				slot_q <= cmd.data;
			end else if (cell_idx > cmd.at) begin
				slot_q <= left;
			end
		end else if (cmd.rem && (cell_idx >= cmd.at)) begin
			slot_q <= right;
		end
	end

	assign slot = slot_q;
	assign take = (cmd.rem && (cell_idx == cmd.at)) ? slot_q : '0;

endmodule

`default_nettype wire

FILE: src/pal_ctrl.sv
// ----------------------------------------------------------------------------
// pal_ctrl
// Decodes an operation against the occupancy count and drives the cell row.
// ----------------------------------------------------------------------------
`default_nettype none

module pal_ctrl (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            fire,
	input  wire  [pal_pkg::FUNC_W-1:0]     func,
	input  wire  [pal_pkg::POS_W-1:0]      position,
	input  wire  [pal_pkg::EDATA_W-1:0]    entry_data,
	output pal_pkg::cmd_t                  cmd,
	output logic [pal_pkg::STAT_W-1:0]     status,
	output logic [pal_pkg::COUNT_W-1:0]    count_after,
	output logic [pal_pkg::COUNT_W-1:0]    count
);
	import pal_pkg::*;

	logic [COUNT_W-1:0] count_q;
	logic [WIDE_W-1:0]  pos_w;
	logic [WIDE_W-1:0]  cnt_w;
	logic               full;
	logic               empty;
	logic               ins_ok;
	logic               rem_ok;
	logic [IDX_W-1:0]   at;

	assign pos_w = WIDE_W'(position);
	assign cnt_w = WIDE_W'(count_q);
	assign full  = (count_q == COUNT_W'(DEPTH));
	assign empty = (count_q == '0);

	always_comb begin
		ins_ok = 1'b0;
		rem_ok = 1'b0;
		at     = '0;
		status = ST_OK;
		case (func)
			F_INS_HEAD: begin
				if (full) status = ST_FULL;
				else ins_ok = 1'b1;
			end
			F_INS_TAIL: begin
				at = IDX_W'(count_q);
				if (full) status = ST_FULL;
				else ins_ok = 1'b1;
			end
			F_INS_POS: begin
				at = IDX_W'(pos_w);
				if (full) status = ST_FULL;
				else if (pos_w > cnt_w) status = ST_RANGE;
				else ins_ok = 1'b1;
			end
			F_REM_HEAD: begin
				if (empty) status = ST_EMPTY;
				else rem_ok = 1'b1;
			end
			F_REM_TAIL: begin
				at = IDX_W'(count_q - COUNT_W'(1));
				if (empty) status = ST_EMPTY;
				else rem_ok = 1'b1;
			end
			F_REM_POS: begin
				at = IDX_W'(pos_w);
				if (empty) status = ST_EMPTY;
				else if (pos_w >= cnt_w) status = ST_RANGE;
				else rem_ok = 1'b1;
			end
			default: ;
		endcase
	end

	always_comb begin
		count_after = count_q;
		if (ins_ok) count_after = count_q + COUNT_W'(1);
		else if (rem_ok) count_after = count_q - COUNT_W'(1);
	end

	assign cmd.ins  = fire && ins_ok;
	assign cmd.rem  = fire && rem_ok;
	assign cmd.at   = at;
	assign cmd.data = DATA_WIDTH'(entry_data);
	assign count    = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (fire) begin
			count_q <= count_after;
		end
	end

endmodule

`default_nettype wire
